### hw/rtl/atsf_pkg.sv
// package for the array tree family search block
// shared constants, status and operation codes; no dependencies
`default_nettype none

package atsf_pkg;

	localparam int DEF_MAX_HEIGHT  = 10;
	localparam int DEF_VALUE_BITS  = 16;
	localparam int DEF_MAX_MATCHES = 64;

	localparam int CFG_BITS    = 4;
	localparam int STATUS_BITS = 3;

	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 4'd10;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [STATUS_BITS-1:0] ST_WRITE_OK  = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_WRITE_REJ = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_MATCH     = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_TRUNC     = 3'd4;

endpackage

`default_nettype wire

### hw/rtl/array_tree_search_family_top.sv
// top level of the array tree family search block
// uses atsf_pkg and one atsf_ram instance holding the node values
`default_nettype none

// Binary tree kept in an array: root at index 1, children of n at 2n and 2n+1.
// Input channel (in_valid/in_ready) carries op, index and value. A write
// (op 0) stores value at index (0 empties the entry) and answers with one
// result, status ok or rejected, loaded from state S_FIN once the output
// is free; in_ready stays low while in S_FIN. A search (op 1) walks
// indices 1 .. 2^height-1 through the node ram's single read port, one entry
// per cycle, and for each match stops to read the parent, sibling and both
// children. Results of a search leave one match behind the scan, since a
// result is sent only once it is known whether it is the last one. Up to
// MAX_MATCHES matches are sent.
// Output channel (out_valid/out_ready) is a register: a new input transfer is
// taken while the final result still waits; while the receiver stalls the
// scan holds at the next match. cfg_we writes tree_height at once.
// After reset a clearing pass writes every node entry empty, one per cycle;
// in_ready stays low until it ends.
module array_tree_search_family_top #(
	parameter int MAX_HEIGHT  = atsf_pkg::DEF_MAX_HEIGHT,
	parameter int VALUE_BITS  = atsf_pkg::DEF_VALUE_BITS,
	parameter int MAX_MATCHES = atsf_pkg::DEF_MAX_MATCHES
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [atsf_pkg::CFG_BITS-1:0]        cfg_wdata,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 op,
	input  wire logic [MAX_HEIGHT-1:0]                index,
	input  wire logic [VALUE_BITS-1:0]                value,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic      [atsf_pkg::STATUS_BITS-1:0]     status,
	output logic      [MAX_HEIGHT-1:0]                found_index,
	output logic                                      parent_present,
	output logic      [VALUE_BITS-1:0]                parent_value,
	output logic                                      left_present,
	output logic      [VALUE_BITS-1:0]                left_value,
	output logic                                      right_present,
	output logic      [VALUE_BITS-1:0]                right_value,
	output logic                                      sibling_present,
	output logic      [VALUE_BITS-1:0]                sibling_value,
	output logic                                      last
);

	localparam int MH    = MAX_HEIGHT;
	localparam int VB    = VALUE_BITS;
	localparam int SB    = atsf_pkg::STATUS_BITS;
	localparam int DEPTH = 1 << MH;
	localparam int MCW   = $clog2(MAX_MATCHES + 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_NBR   = 6'b001000,
		S_PUSH  = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	typedef enum logic [4:0] {
		N_PAR = 5'b00001,
		N_SIB = 5'b00010,
		N_LFT = 5'b00100,
		N_RGT = 5'b01000,
		N_END = 5'b10000
	} nstep_t;

	state_t                       state_q;
	nstep_t                       nstep_q;
	logic [atsf_pkg::CFG_BITS-1:0] height_q;
	logic [atsf_pkg::CFG_BITS-1:0] h_use;
	logic [MH:0]                  count_w;
	logic [MH-1:0]                clr_q;
	logic [MH:0]                  scan_q;
	logic                         chk_vld_s1;
	logic [MH-1:0]                chk_idx_s1;
	logic [MH-1:0]                m_idx_q;
	logic [MCW-1:0]               match_cnt_q;
	logic [VB-1:0]                key_q;

	// match being assembled from neighbor reads
	logic          cur_pp_q, cur_lp_q, cur_rp_q, cur_sp_q;
	logic [VB-1:0] cur_pv_q, cur_lv_q, cur_rv_q, cur_sv_q;

	// result held back until it is known whether it is the last one
	logic          pend_vld_q;
	logic [SB-1:0] pend_status_q;
	logic [MH-1:0] pend_idx_q;
	logic          pend_pp_q, pend_lp_q, pend_rp_q, pend_sp_q;
	logic [VB-1:0] pend_pv_q, pend_lv_q, pend_rv_q, pend_sv_q;

	logic          out_vld_q;
	logic [SB-1:0] status_q;
	logic [MH-1:0] found_index_q;
	logic          pp_q, lp_q, rp_q, sp_q, last_q;
	logic [VB-1:0] pv_q, lv_q, rv_q, sv_q;

	logic          ram_we;
	logic [MH-1:0] ram_waddr;
	logic [VB-1:0] ram_wdata;
	logic [MH-1:0] ram_raddr;
	logic [VB-1:0] rd_data;

	logic          in_xfer;
	logic          wr_ok;
	logic          out_free;
	logic          out_load;
	logic          out_sel_pend;
	logic          out_last_v;
	logic          push_go;
	logic          hit;
	logic          not_root;
	logic          child_ok;
	logic [MH:0]   child_w;
	logic          rd_nz;

	atsf_ram #(
		.WIDTH(VB),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// heights of zero and above the maximum are clamped
	always_comb begin
		if (height_q == '0) begin
			h_use = atsf_pkg::CFG_BITS'(1);
		end else if (int'(height_q) > MH) begin
			h_use = atsf_pkg::CFG_BITS'(MH);
		end else begin
			h_use = height_q;
		end
	end

	assign count_w  = (MH+1)'(1) << h_use;
	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign wr_ok    = (index != '0) && ({1'b0, index} < count_w);
	assign out_free = !out_vld_q || out_ready;
	assign hit      = chk_vld_s1 && (key_q != '0) && (rd_data == key_q);
	assign not_root = (m_idx_q != MH'(1));
	assign child_w  = {m_idx_q, 1'b0};
	assign child_ok = (child_w < count_w);
	assign rd_nz    = (rd_data != '0);
	assign push_go  = (state_q == S_PUSH) && (!pend_vld_q || out_free);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = index;
		ram_wdata = value;
		ram_raddr = scan_q[MH-1:0];
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				ram_we = in_xfer && (op == atsf_pkg::OP_WRITE) && wr_ok;
			end
			S_NBR: begin
				unique case (nstep_q)
					N_PAR: ram_raddr = m_idx_q >> 1;
					N_SIB: ram_raddr = m_idx_q ^ MH'(1);
					N_LFT: ram_raddr = child_w[MH-1:0];
					N_RGT: ram_raddr = child_w[MH-1:0] | MH'(1);
					N_END: ram_raddr = scan_q[MH-1:0];
					default: ram_raddr = scan_q[MH-1:0];
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		out_load     = 1'b0;
		out_sel_pend = 1'b1;
		out_last_v   = 1'b1;
		if (push_go && pend_vld_q) begin
			out_load   = 1'b1;
			out_last_v = 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_load     = 1'b1;
			out_sel_pend = pend_vld_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			nstep_q     <= N_PAR;
			height_q    <= atsf_pkg::HEIGHT_RESET;
			clr_q       <= '0;
			scan_q      <= '0;
			chk_vld_s1  <= 1'b0;
			match_cnt_q <= '0;
			pend_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				height_q <= cfg_wdata;
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + MH'(1);
					if (clr_q == {MH{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						if (op == atsf_pkg::OP_WRITE) begin
							pend_vld_q <= 1'b1;
							state_q    <= S_FIN;
						end else begin
							pend_vld_q  <= 1'b0;
							match_cnt_q <= '0;
							scan_q      <= (MH+1)'(1);
							chk_vld_s1  <= 1'b0;
							state_q     <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						chk_vld_s1 <= 1'b0;
						if (match_cnt_q == MCW'(MAX_MATCHES)) begin
							state_q <= S_FIN;
						end else begin
							nstep_q <= N_PAR;
							state_q <= S_NBR;
						end
					end else if (scan_q < count_w) begin
						chk_vld_s1 <= 1'b1;
						scan_q     <= scan_q + (MH+1)'(1);
					end else begin
						chk_vld_s1 <= 1'b0;
						if (!chk_vld_s1) begin
							state_q <= S_FIN;
						end
					end
				end
				S_NBR: begin
					unique case (nstep_q)
						N_PAR: nstep_q <= N_SIB;
						N_SIB: nstep_q <= N_LFT;
						N_LFT: nstep_q <= N_RGT;
						N_RGT: nstep_q <= N_END;
						N_END: state_q <= S_PUSH;
						default: nstep_q <= N_PAR;
					endcase
				end
				S_PUSH: begin
					if (push_go) begin
						pend_vld_q  <= 1'b1;
						match_cnt_q <= match_cnt_q + MCW'(1);
						scan_q      <= (MH+1)'(m_idx_q) + (MH+1)'(1);
						state_q     <= S_SCAN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			key_q         <= value;
			pend_status_q <= wr_ok ? atsf_pkg::ST_WRITE_OK : atsf_pkg::ST_WRITE_REJ;
			pend_idx_q    <= index;
			pend_pp_q     <= 1'b0;
			pend_lp_q     <= 1'b0;
			pend_rp_q     <= 1'b0;
			pend_sp_q     <= 1'b0;
			pend_pv_q     <= '0;
			pend_lv_q     <= '0;
			pend_rv_q     <= '0;
			pend_sv_q     <= '0;
		end

		if (state_q == S_SCAN) begin
			if (scan_q < count_w) begin
				chk_idx_s1 <= scan_q[MH-1:0];
			end
			if (hit) begin
				m_idx_q <= chk_idx_s1;
				if (match_cnt_q == MCW'(MAX_MATCHES)) begin
					pend_status_q <= atsf_pkg::ST_TRUNC;
				end
			end
		end

		// each step captures the read issued by the step before it
		if (state_q == S_NBR) begin
			case (nstep_q)
				N_SIB: begin
					cur_pp_q <= not_root && rd_nz;
					cur_pv_q <= not_root ? rd_data : '0;
				end
				N_LFT: begin
					cur_sp_q <= not_root && rd_nz;
					cur_sv_q <= not_root ? rd_data : '0;
				end
				N_RGT: begin
					cur_lp_q <= child_ok && rd_nz;
					cur_lv_q <= child_ok ? rd_data : '0;
				end
				N_END: begin
					cur_rp_q <= child_ok && rd_nz;
					cur_rv_q <= child_ok ? rd_data : '0;
				end
				default: ;
			endcase
		end

		if (out_load) begin
			last_q <= out_last_v;
			if (out_sel_pend) begin
				status_q      <= pend_status_q;
				found_index_q <= pend_idx_q;
				pp_q          <= pend_pp_q;
				pv_q          <= pend_pv_q;
				lp_q          <= pend_lp_q;
				lv_q          <= pend_lv_q;
				rp_q          <= pend_rp_q;
				rv_q          <= pend_rv_q;
				sp_q          <= pend_sp_q;
				sv_q          <= pend_sv_q;
			end else begin
				status_q      <= atsf_pkg::ST_NOT_FOUND;
				found_index_q <= '0;
				pp_q          <= 1'b0;
				pv_q          <= '0;
				lp_q          <= 1'b0;
				lv_q          <= '0;
				rp_q          <= 1'b0;
				rv_q          <= '0;
				sp_q          <= 1'b0;
				sv_q          <= '0;
			end
		end

		if (push_go) begin
			pend_status_q <= atsf_pkg::ST_MATCH;
			pend_idx_q    <= m_idx_q;
			pend_pp_q     <= cur_pp_q;
			pend_pv_q     <= cur_pv_q;
			pend_lp_q     <= cur_lp_q;
			pend_lv_q     <= cur_lv_q;
			pend_rp_q     <= cur_rp_q;
			pend_rv_q     <= cur_rv_q;
			pend_sp_q     <= cur_sp_q;
			pend_sv_q     <= cur_sv_q;
		end
	end

	assign out_valid       = out_vld_q;
	assign status          = status_q;
	assign found_index     = found_index_q;
	assign parent_present  = pp_q;
	assign parent_value    = pv_q;
	assign left_present    = lp_q;
	assign left_value      = lv_q;
	assign right_present   = rp_q;
	assign right_value     = rv_q;
	assign sibling_present = sp_q;
	assign sibling_value   = sv_q;
	assign last            = last_q;

	// store is written only by the clearing pass or an accepted write
	a_we_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_IDLE))
		else $error("node ram written outside clear or idle");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		match_cnt_q <= MCW'(MAX_MATCHES))
		else $error("match count above limit");

	// an empty holding slot during a push means this is the first match
	a_first_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH && !pend_vld_q) |-> (match_cnt_q == '0))
		else $error("holding slot empty after earlier matches");

	// the scan never looks at index zero
	a_no_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && chk_vld_s1) |-> (chk_idx_s1 != '0))
		else $error("scan checked index zero");

	// a stalled result is never replaced
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_ready) |=> (out_vld_q && $stable(found_index_q)
			&& $stable(status_q) && $stable(last_q)))
		else $error("waiting result overwritten");

endmodule

`default_nettype wire

### hw/rtl/atsf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module atsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### tb/sv/atsf_family_checker.sv
// checker for the array tree family search block: watches both channels and the
// height register port, predicts every result and compares it with the block
// depends on atsf_pkg only
module atsf_family_checker #(
	parameter int MAX_HEIGHT  = atsf_pkg::DEF_MAX_HEIGHT,
	parameter int VALUE_BITS  = atsf_pkg::DEF_VALUE_BITS,
	parameter int MAX_MATCHES = atsf_pkg::DEF_MAX_MATCHES
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [atsf_pkg::CFG_BITS-1:0]    cfg_wdata,
	input  wire logic                             in_valid,
	input  wire logic                             in_ready,
	input  wire logic                             op,
	input  wire logic [MAX_HEIGHT-1:0]            index,
	input  wire logic [VALUE_BITS-1:0]            value,
	input  wire logic                             out_valid,
	input  wire logic                             out_ready,
	input  wire logic [atsf_pkg::STATUS_BITS-1:0] status,
	input  wire logic [MAX_HEIGHT-1:0]            found_index,
	input  wire logic                             parent_present,
	input  wire logic [VALUE_BITS-1:0]            parent_value,
	input  wire logic                             left_present,
	input  wire logic [VALUE_BITS-1:0]            left_value,
	input  wire logic                             right_present,
	input  wire logic [VALUE_BITS-1:0]            right_value,
	input  wire logic                             sibling_present,
	input  wire logic [VALUE_BITS-1:0]            sibling_value,
	input  wire logic                             last,
	output int unsigned                           mismatches,
	output int unsigned                           answers_due
);
	import atsf_pkg::*;

	localparam int DEPTH = 1 << MAX_HEIGHT;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [MAX_HEIGHT-1:0]  found_index;
		logic                   parent_present;
		logic [VALUE_BITS-1:0]  parent_value;
		logic                   left_present;
		logic [VALUE_BITS-1:0]  left_value;
		logic                   right_present;
		logic [VALUE_BITS-1:0]  right_value;
		logic                   sibling_present;
		logic [VALUE_BITS-1:0]  sibling_value;
		logic                   last;
	} family_t;

	bit                    node_held [DEPTH];
	logic [VALUE_BITS-1:0] node_data [DEPTH];
	logic [CFG_BITS-1:0]   height_reg;
	family_t               answers [$];

	// zero acts as one level, anything above the maximum as the maximum
	function automatic int levels_in_use();
		if (height_reg == '0)
			return 1;
		if (int'(height_reg) > MAX_HEIGHT)
			return MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function automatic void peek_node(input int at, input int span, output logic pres,
			output logic [VALUE_BITS-1:0] v);
		pres = 1'b0;
		v = '0;
		if (at < span && at < DEPTH && node_held[at]) begin
			pres = 1'b1;
			v = node_data[at];
		end
	endfunction

	function automatic string show(input family_t f);
		return $sformatf("st=%0d idx=%0d par=%0b/%h left=%0b/%h right=%0b/%h sib=%0b/%h last=%0b",
			f.status, f.found_index, f.parent_present, f.parent_value, f.left_present,
			f.left_value, f.right_present, f.right_value, f.sibling_present,
			f.sibling_value, f.last);
	endfunction

	task automatic predict_request(input logic req_op, input logic [MAX_HEIGHT-1:0] at,
			input logic [VALUE_BITS-1:0] key);
		int      span;
		int      p;
		int      hits;
		bit      dropped;
		family_t f;
		span = 1 << levels_in_use();
		f = '0;
		if (req_op == OP_WRITE) begin
			f.found_index = at;
			f.last = 1'b1;
			if (at == '0 || int'(at) >= span) begin
				f.status = ST_WRITE_REJ;
			end else begin
				f.status = ST_WRITE_OK;
				node_held[at] = (key != '0);
				node_data[at] = key;
			end
			answers.push_back(f);
		end else begin
			hits = 0;
			dropped = 1'b0;
			for (p = 1; p < span && !dropped; p++) begin
				if (node_held[p] && node_data[p] == key) begin
					if (hits >= MAX_MATCHES) begin
						// one match too many: the last one sent carries the truncation mark
						f = answers.pop_back();
						f.status = ST_TRUNC;
						answers.push_back(f);
						dropped = 1'b1;
					end else begin
						f = '0;
						f.status = ST_MATCH;
						f.found_index = MAX_HEIGHT'(p);
						if (p != 1) begin
							peek_node(p >> 1, span, f.parent_present, f.parent_value);
							peek_node(p ^ 1, span, f.sibling_present, f.sibling_value);
						end
						peek_node(2 * p, span, f.left_present, f.left_value);
						peek_node(2 * p + 1, span, f.right_present, f.right_value);
						answers.push_back(f);
						hits++;
					end
				end
			end
			if (hits == 0) begin
				f = '0;
				f.status = ST_NOT_FOUND;
				f.last = 1'b1;
				answers.push_back(f);
			end else begin
				f = answers.pop_back();
				f.last = 1'b1;
				answers.push_back(f);
			end
		end
	endtask

	task automatic check_result();
		family_t got;
		family_t want;
		got = {status, found_index, parent_present, parent_value, left_present, left_value,
			right_present, right_value, sibling_present, sibling_value, last};
		if (answers.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result transfer: %s", show(got));
		end else begin
			want = answers.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch\n  expected %s\n  actual   %s",
						show(want), show(got));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				node_held[i] = 1'b0;
				node_data[i] = '0;
			end
			height_reg = HEIGHT_RESET;
			answers.delete();
			mismatches = 0;
			answers_due = 0;
		end else begin
			// a result leaving at this edge can never belong to a request taken at it
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				predict_request(op, index, value);
			if (cfg_we)
				height_reg = cfg_wdata;
			answers_due = answers.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
// testbench top for the array tree family search block: drives requests, the
// height register and result back-pressure; atsf_family_checker judges results
// depends on atsf_pkg, array_tree_search_family_top and atsf_family_checker
module tb_top;
	import atsf_pkg::*;

	localparam int MAX_HEIGHT  = DEF_MAX_HEIGHT;
	localparam int VALUE_BITS  = DEF_VALUE_BITS;
	localparam int MAX_MATCHES = DEF_MAX_MATCHES;
	localparam int CYCLE_LIMIT = 2_000_000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_BITS-1:0]    cfg_wdata = '0;
	logic                   in_valid = 1'b0;
	logic                   op = OP_WRITE;
	logic [MAX_HEIGHT-1:0]  index = '0;
	logic [VALUE_BITS-1:0]  value = '0;
	logic                   out_ready = 1'b0;

	logic                   in_ready;
	logic                   out_valid;
	logic [STATUS_BITS-1:0] status;
	logic [MAX_HEIGHT-1:0]  found_index;
	logic                   parent_present;
	logic [VALUE_BITS-1:0]  parent_value;
	logic                   left_present;
	logic [VALUE_BITS-1:0]  left_value;
	logic                   right_present;
	logic [VALUE_BITS-1:0]  right_value;
	logic                   sibling_present;
	logic [VALUE_BITS-1:0]  sibling_value;
	logic                   last;

	int unsigned            mismatches;
	int unsigned            answers_due;
	int unsigned            cycles = 0;
	logic                   calm = 1'b0;
	logic                   squeeze_req = 1'b0;
	logic [VALUE_BITS-1:0]  keys [3];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	array_tree_search_family_top #(
		.MAX_HEIGHT(MAX_HEIGHT),
		.VALUE_BITS(VALUE_BITS),
		.MAX_MATCHES(MAX_MATCHES)
	) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .index(index), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.found_index(found_index), .parent_present(parent_present),
		.parent_value(parent_value), .left_present(left_present), .left_value(left_value),
		.right_present(right_present), .right_value(right_value),
		.sibling_present(sibling_present), .sibling_value(sibling_value), .last(last)
	);

	atsf_family_checker #(
		.MAX_HEIGHT(MAX_HEIGHT),
		.VALUE_BITS(VALUE_BITS),
		.MAX_MATCHES(MAX_MATCHES)
	) chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .index(index), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.found_index(found_index), .parent_present(parent_present),
		.parent_value(parent_value), .left_present(left_present), .left_value(left_value),
		.right_present(right_present), .right_value(right_value),
		.sibling_present(sibling_present), .sibling_value(sibling_value), .last(last),
		.mismatches(mismatches), .answers_due(answers_due)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold-off, none once calm
	initial begin : result_sink
		int  stall;
		bit  held_once;
		stall = 0;
		held_once = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req && !held_once) begin
				held_once = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (calm) begin
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one request transfer, with an occasional gap in front of it
	task automatic offer(input logic o, input logic [MAX_HEIGHT-1:0] at,
			input logic [VALUE_BITS-1:0] v);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		index <= at;
		value <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (answers_due != 0)
			@(negedge clk);
	endtask

	// the height only changes with nothing in flight
	task automatic set_height(input logic [CFG_BITS-1:0] h);
		drain();
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item(input int span);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			offer(OP_WRITE, MAX_HEIGHT'($urandom_range(1, span - 1)),
				keys[$urandom_range(0, 2)]);
		else if (pick == 4)
			offer(OP_WRITE, MAX_HEIGHT'($urandom_range(1, span - 1)), '0);
		else if (pick < 8)
			offer(OP_SEARCH, MAX_HEIGHT'($urandom), keys[$urandom_range(0, 2)]);
		else if (pick == 8)
			offer(OP_WRITE, MAX_HEIGHT'($urandom), VALUE_BITS'($urandom));
		else
			offer(OP_SEARCH, MAX_HEIGHT'($urandom), VALUE_BITS'($urandom));
	endtask

	// mostly writes and searches over a small key set so that searches hit
	task automatic random_phase(input logic [CFG_BITS-1:0] h, input int n);
		int levels;
		set_height(h);
		levels = (h == '0) ? 1 : ((int'(h) > MAX_HEIGHT) ? MAX_HEIGHT : int'(h));
		foreach (keys[k])
			keys[k] = VALUE_BITS'($urandom_range(1, 65535));
		repeat (n)
			random_item(1 << levels);
	endtask

	initial begin : stimulus
		logic [VALUE_BITS-1:0] key;
		logic [MAX_HEIGHT-1:0] slot;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset height: the deepest index is legal
		offer(OP_WRITE, 10'd1023, 16'hFFFF);
		offer(OP_WRITE, 10'd511, 16'h0001);
		offer(OP_SEARCH, 10'd0, 16'hFFFF);

		set_height(4'd3);
		offer(OP_WRITE, 10'd0, 16'h0005);
		offer(OP_WRITE, 10'd8, 16'h0005);
		offer(OP_WRITE, 10'd1023, 16'h0005);
		offer(OP_WRITE, 10'd1, 16'h8001);
		offer(OP_WRITE, 10'd2, 16'h0007);
		offer(OP_WRITE, 10'd3, 16'h0007);
		offer(OP_WRITE, 10'd4, 16'h0009);
		offer(OP_WRITE, 10'd5, 16'h0007);
		offer(OP_WRITE, 10'd6, 16'h8001);
		offer(OP_WRITE, 10'd7, 16'hFFFF);
		offer(OP_SEARCH, 10'd0, 16'h0007);
		offer(OP_SEARCH, 10'd1023, 16'h8001);
		offer(OP_SEARCH, 10'd0, 16'h0000);
		offer(OP_SEARCH, 10'd0, 16'h1234);
		offer(OP_SEARCH, 10'd0, 16'hFFFF);
		// emptied entry drops out as a neighbor
		offer(OP_WRITE, 10'd4, 16'h0000);
		offer(OP_SEARCH, 10'd0, 16'h0007);

		// zero acts as one level: children out of range although stored
		set_height(4'd0);
		offer(OP_WRITE, 10'd1, 16'h0007);
		offer(OP_WRITE, 10'd2, 16'h0007);
		offer(OP_SEARCH, 10'd0, 16'h0007);

		// above the maximum acts as the maximum
		set_height(4'd15);
		offer(OP_SEARCH, 10'd0, 16'hFFFF);

		random_phase(4'd1, 4);
		random_phase(4'd4, 5);
		random_phase(4'd10, 3);
		random_phase(4'd5, 4);

		// fill past the match limit while the result side holds off
		set_height(4'd7);
		squeeze_req <= 1'b1;
		key = VALUE_BITS'($urandom_range(1, 65535));
		for (int i = 1; i <= MAX_MATCHES + 2; i++) begin
			slot = MAX_HEIGHT'(i);
			offer(OP_WRITE, slot, key);
		end
		offer(OP_SEARCH, MAX_HEIGHT'($urandom), key);
		offer(OP_SEARCH, MAX_HEIGHT'($urandom), VALUE_BITS'($urandom));

		calm <= 1'b1;
		random_phase(4'd2, 4);

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && answers_due == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
